// ===== rtl/core/msra_pkg.sv =====
`default_nettype none

package msra_pkg;

    localparam int SOURCE_POINTS = 4096;
    localparam int TARGET_POINTS = 4096;
    localparam int SRC_AW = $clog2(SOURCE_POINTS);
    localparam int TGT_AW = $clog2(TARGET_POINTS);

    localparam int IDX_W = 12;
    localparam int DATA_W = 32;
    localparam int WEIGHT_W = 18;
    localparam int ACC_W = 48;
    localparam int PROD_W = DATA_W + WEIGHT_W;
    localparam int FRAC_W = 16;

    // Input word layout, lowest bit first.
    localparam int IN_TDATA_W = 80;
    localparam int TGT_LSB = 0;
    localparam int SRC_LSB = TGT_LSB + IDX_W;
    localparam int SMP_LSB = SRC_LSB + IDX_W;
    localparam int SVLD_BIT = SMP_LSB + DATA_W;
    localparam int WGT_LSB = SVLD_BIT + 1;
    localparam int PVLD_BIT = WGT_LSB + WEIGHT_W;

    localparam int ACTION_W = 2;
    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WEIGHT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_EMIT = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MASK = 2'd2;

    typedef struct packed {
        logic load;
        logic use_fill;
    } mac_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/masked_sparse_remap_accumulate_unit.sv =====
// Load words write the source memory. Weight words pass through memory read,
// multiply, and saturating add with write back in the accumulator memory,
// with s_tready low until the write. Emit words read the accumulator, then
// register their result onto m_tdata, held back while an earlier result
// still waits on m_tready. After reset the accumulator memory is cleared one
// entry a cycle, with s_tready low; configuration writes are taken throughout.
`default_nettype none

module masked_sparse_remap_accumulate_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // target_index[11:0], source_index[23:12], sample_value[55:24],
    // sample_valid[56], weight[74:57], point_valid[75], zero[79:76]
    input  logic [msra_pkg::IN_TDATA_W-1:0]      s_tdata,
    // action[1:0]
    input  logic [msra_pkg::ACTION_W-1:0]        s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_value[31:0]
    output logic [msra_pkg::DATA_W-1:0]          m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [msra_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [msra_pkg::DATA_W-1:0]          cfg_data
);
    import msra_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_WRITE,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [TGT_AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [TGT_AW-1:0]          ptr_reg, ptr_next;
    logic [TGT_AW-1:0]          row_reg, row_next;
    logic signed [WEIGHT_W-1:0] weight_reg, weight_next;
    logic                       masked_reg, masked_next;
    logic                       last_reg, last_next;
    logic [DATA_W-1:0]          out_value_reg, out_value_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_valid_reg, out_valid_next;

    logic signed [DATA_W-1:0]   fill_reg;
    logic                       smask_reg;
    logic                       tmask_reg;

    logic [IDX_W-1:0]  in_tgt;
    logic [IDX_W-1:0]  in_src;
    logic [DATA_W-1:0] in_sample;
    logic              in_svalid;
    logic              in_pvalid;
    logic              accept;
    logic              src_ok;
    logic              tgt_ok;

    logic              src_we, src_re;
    logic [DATA_W:0]   src_rdata;
    logic              acc_we, acc_re;
    logic [TGT_AW-1:0] acc_waddr, acc_raddr;
    logic [ACC_W-1:0]  acc_wdata, acc_rdata, mac_result;
    logic [DATA_W-1:0] acc_sat32;
    logic              out_free;
    mac_ctl_t          mac_ctl;

    assign in_tgt    = s_tdata[TGT_LSB +: IDX_W];
    assign in_src    = s_tdata[SRC_LSB +: IDX_W];
    assign in_sample = s_tdata[SMP_LSB +: DATA_W];
    assign in_svalid = s_tdata[SVLD_BIT];
    assign in_pvalid = s_tdata[PVLD_BIT];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign src_ok   = 32'(in_src) < SOURCE_POINTS;
    assign tgt_ok   = 32'(in_tgt) < TARGET_POINTS;
    assign out_free = !out_valid_reg || m_tready;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_value_reg;
    assign m_tlast   = out_last_reg;

    // The valid bit rides on top of the sample in the source memory.
    assign src_we = accept && (s_tuser == ACT_LOAD) && src_ok;
    assign src_re = accept && (s_tuser == ACT_WEIGHT);

    msra_ram #(
        .WIDTH(DATA_W + 1),
        .DEPTH(SOURCE_POINTS)
    ) u_src_ram (
        .aclk  (aclk),
        .we    (src_we),
        .waddr (SRC_AW'(in_src)),
        .wdata ({in_svalid, in_sample}),
        .re    (src_re),
        .raddr (SRC_AW'(in_src)),
        .rdata (src_rdata)
    );

    msra_ram #(
        .WIDTH(ACC_W),
        .DEPTH(TARGET_POINTS)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    assign mac_ctl.load     = (state_reg == ST_MUL);
    assign mac_ctl.use_fill = smask_reg && !src_rdata[DATA_W];

    msra_mac u_mac (
        .aclk       (aclk),
        .ctl        (mac_ctl),
        .weight     (weight_reg),
        .sample     (src_rdata[DATA_W-1:0]),
        .acc_in     (acc_rdata),
        .fill_word  (fill_reg),
        .acc_out    (mac_result)
    );

    always_comb begin
        if (acc_rdata[ACC_W-1:DATA_W-1] == {(ACC_W - DATA_W + 1){acc_rdata[ACC_W-1]}}) begin
            acc_sat32 = acc_rdata[DATA_W-1:0];
        end else if (acc_rdata[ACC_W-1]) begin
            acc_sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            acc_sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ptr_next       = ptr_reg;
        row_next       = row_reg;
        weight_next    = weight_reg;
        masked_next    = masked_reg;
        last_next      = last_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;
        acc_we         = 1'b0;
        acc_waddr      = clr_cnt_reg;
        acc_wdata      = '0;
        acc_re         = 1'b0;
        acc_raddr      = ptr_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                acc_we = 1'b1;
                clr_cnt_next = clr_cnt_reg + TGT_AW'(1);
                if (clr_cnt_reg == TGT_AW'(TARGET_POINTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                row_next    = TGT_AW'(in_tgt);
                weight_next = s_tdata[WGT_LSB +: WEIGHT_W];
                masked_next = tmask_reg && !in_pvalid;
                last_next   = s_tlast;
                if (accept) begin
                    if (s_tuser == ACT_WEIGHT && src_ok && tgt_ok) begin
                        acc_re = 1'b1;
                        acc_raddr = TGT_AW'(in_tgt);
                        state_next = ST_MUL;
                    end else if (s_tuser == ACT_EMIT) begin
                        acc_re = !(tmask_reg && !in_pvalid);
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                acc_we = 1'b1;
                acc_waddr = row_reg;
                acc_wdata = mac_result;
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = last_reg;
                    if (masked_reg) begin
                        out_value_next = fill_reg;
                    end else begin
                        out_value_next = acc_sat32;
                        acc_we = 1'b1;
                        acc_waddr = ptr_reg;
                        ptr_next = (ptr_reg == TGT_AW'(TARGET_POINTS - 1))
                                 ? '0 : ptr_reg + TGT_AW'(1);
                    end
                    if (last_reg) begin
                        ptr_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
            smask_reg     <= 1'b0;
            tmask_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_FILL_VALUE:  fill_reg  <= cfg_data;
                    REG_SOURCE_MASK: smask_reg <= cfg_data[0];
                    REG_TARGET_MASK: tmask_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        row_reg       <= row_next;
        weight_reg    <= weight_next;
        masked_reg    <= masked_next;
        last_reg      <= last_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/msra_ram.sv =====
`default_nettype none

module msra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/msra_mac.sv =====
`default_nettype none

module msra_mac (
    input  logic                                   aclk,
    input  msra_pkg::mac_ctl_t                     ctl,
    input  logic signed [msra_pkg::WEIGHT_W-1:0]   weight,
    input  logic signed [msra_pkg::DATA_W-1:0]     sample,
    input  logic signed [msra_pkg::ACC_W-1:0]      acc_in,
    input  logic signed [msra_pkg::DATA_W-1:0]     fill_word,
    output logic signed [msra_pkg::ACC_W-1:0]      acc_out
);
    import msra_pkg::*;

    localparam int TERM_W = PROD_W - FRAC_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     use_fill_reg;

    logic [TERM_W-1:0] term;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  sat_sum;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            prod_reg <= PROD_W'(weight) * PROD_W'(sample);
            acc_reg <= acc_in;
            use_fill_reg <= ctl.use_fill;
        end
    end

    // Dropping the low fraction bits of a two's complement product rounds
    // toward minus infinity.
    assign term = prod_reg[PROD_W-1:FRAC_W];
    assign sum = {acc_reg[ACC_W-1], acc_reg}
               + {{(ACC_W + 1 - TERM_W){term[TERM_W-1]}}, term};

    always_comb begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat_sum = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_sum = sum[ACC_W-1:0];
        end
    end

    assign acc_out = use_fill_reg
                   ? {{(ACC_W - DATA_W){fill_word[DATA_W-1]}}, fill_word}
                   : sat_sum;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import msra_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int unsigned LIMIT_CYCLES = 1500000;
    localparam int DRAIN_CYCLES = 16;
    localparam int DEFAULT_IDLE_PCT = 33;
    localparam longint ACC_HI = (longint'(1) <<< 47) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< 47);
    localparam longint OUT_HI = (longint'(1) <<< 31) - 1;
    localparam longint OUT_LO = -(longint'(1) <<< 31);

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [IDX_W-1:0]    tgt;
        logic [IDX_W-1:0]    src;
        logic [DATA_W-1:0]   sample;
        logic                smp_valid;
        logic [WEIGHT_W-1:0] weight;
        logic                pt_valid;
        logic                last;
    } remap_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
    } point_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [ACTION_W-1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    masked_sparse_remap_accumulate_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predicted block state and configuration.
    logic [DATA_W-1:0] src_sample [SOURCE_POINTS];
    bit src_vld [SOURCE_POINTS];
    longint acc [TARGET_POINTS];
    bit [TGT_AW-1:0] read_ptr = '0;
    bit [DATA_W-1:0] fill_q = '0;
    bit smask_q = 1'b0;
    bit tmask_q = 1'b0;

    remap_word_t pending_words [$];
    point_t expected_points [$];
    remap_word_t cur_word;
    bit word_pending = 1'b0;
    point_t due;

    // Stimulus bookkeeping: columns that hold a loaded sample.
    bit col_loaded [SOURCE_POINTS];
    idx_t loaded_cols [$];
    int stimulus_words = 0;

    int send_idle_pct = DEFAULT_IDLE_PCT;
    int recv_stall_pct = DEFAULT_IDLE_PCT;
    int mismatches = 0;
    int unsigned cycle_count = 0;

    function automatic longint sat_acc48(longint v);
        if (v > ACC_HI) begin
            return ACC_HI;
        end
        if (v < ACC_LO) begin
            return ACC_LO;
        end
        return v;
    endfunction

    function automatic void apply_remap_word(remap_word_t w);
        longint term;
        longint point;
        point_t res;
        case (w.action)
            ACT_LOAD: begin
                src_sample[w.src] = w.sample;
                src_vld[w.src] = w.smp_valid;
            end
            ACT_WEIGHT: begin
                if (smask_q && !src_vld[w.src]) begin
                    acc[w.tgt] = sat_acc48(longint'($signed(fill_q)));
                end else begin
                    // Arithmetic shift rounds the Q34.16 product toward minus infinity.
                    term = (longint'($signed(w.weight)) * longint'($signed(src_sample[w.src])))
                           >>> FRAC_W;
                    acc[w.tgt] = sat_acc48(acc[w.tgt] + term);
                end
            end
            ACT_EMIT: begin
                if (tmask_q && !w.pt_valid) begin
                    point = longint'($signed(fill_q));
                end else begin
                    point = acc[read_ptr];
                    if (point > OUT_HI) begin
                        point = OUT_HI;
                    end
                    if (point < OUT_LO) begin
                        point = OUT_LO;
                    end
                    acc[read_ptr] = 0;
                    read_ptr = read_ptr + 1'b1;
                end
                if (w.last) begin
                    read_ptr = '0;
                end
                res.value = point[DATA_W-1:0];
                res.last = w.last;
                expected_points = {expected_points, res};
            end
            default: begin
            end
        endcase
    endfunction

    function automatic remap_word_t make_word(logic [ACTION_W-1:0] act, idx_t tgt, idx_t src,
                                              logic [DATA_W-1:0] smp, logic sv,
                                              logic [WEIGHT_W-1:0] wgt, logic pv, logic lst);
        remap_word_t w;
        w.action = act;
        w.tgt = tgt;
        w.src = src;
        w.sample = smp;
        w.smp_valid = sv;
        w.weight = wgt;
        w.pt_valid = pv;
        w.last = lst;
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] rand_sample();
        logic [31:0] r;
        logic [DATA_W-1:0] v;
        r = $urandom;
        case ($urandom_range(7))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = {{15{r[16]}}, r[16:0]};
            default: v = r;
        endcase
        return v;
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        logic [31:0] r;
        logic [WEIGHT_W-1:0] v;
        r = $urandom;
        case ($urandom_range(7))
            0: v = 18'h20000;
            1: v = 18'h1FFFF;
            2: v = 18'h10000;
            default: v = r[WEIGHT_W-1:0];
        endcase
        return v;
    endfunction

    // Every field random, so that unused fields toggle as well.
    function automatic remap_word_t rand_word();
        remap_word_t w;
        logic [31:0] r;
        r = $urandom;
        w.action = r[1:0];
        w.tgt = r[13:2];
        w.src = r[25:14];
        w.smp_valid = r[26];
        w.pt_valid = r[27];
        w.last = r[28];
        w.sample = rand_sample();
        w.weight = rand_weight();
        return w;
    endfunction

    function automatic void queue_word(remap_word_t w);
        if (w.action == ACT_LOAD && !col_loaded[w.src]) begin
            col_loaded[w.src] = 1'b1;
            loaded_cols = {loaded_cols, w.src};
        end
        if (w.action != ACT_UNUSED) begin
            stimulus_words++;
        end
        pending_words = {pending_words, w};
    endfunction

    // One frame: some loads, weights on loaded columns only (now and then with an unused word), then a run of points.
    task automatic add_random_frame();
        remap_word_t w;
        int n_load;
        int n_wt;
        int n_pts;
        int k;
        bit broken;
        n_pts = $urandom_range(1, 12);
        n_load = (loaded_cols.size() == 0) ? 4 : $urandom_range(0, 6);
        n_wt = $urandom_range(0, 20);
        broken = ($urandom_range(9) == 0);
        for (k = 0; k < n_load; k++) begin
            w = rand_word();
            w.action = ACT_LOAD;
            if ($urandom_range(3) != 0) begin
                w.src = {6'd0, w.src[5:0]};
            end
            queue_word(w);
        end
        for (k = 0; k < n_wt; k++) begin
            w = rand_word();
            w.action = ACT_WEIGHT;
            w.src = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
            if ($urandom_range(4) != 0) begin
                w.tgt = idx_t'($urandom_range(n_pts - 1));
            end
            queue_word(w);
            if ($urandom_range(19) == 0) begin
                w = rand_word();
                w.action = ACT_UNUSED;
                queue_word(w);
            end
        end
        for (k = 0; k < n_pts; k++) begin
            w = rand_word();
            w.action = ACT_EMIT;
            w.last = (k == n_pts - 1) && !broken;
            queue_word(w);
        end
    endtask

    task automatic random_phase(int n_words);
        int start;
        start = stimulus_words;
        while (stimulus_words - start < n_words) begin
            add_random_frame();
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || word_pending || expected_points.size() != 0) begin
            @(posedge aclk);
        end
        // Weight words leave no result, so give the pipeline time to settle.
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        case (idx)
            REG_FILL_VALUE: fill_q = data;
            REG_SOURCE_MASK: smask_q = data[0];
            REG_TARGET_MASK: tmask_q = data[0];
            default: begin
            end
        endcase
    endtask

    task automatic set_config(logic [DATA_W-1:0] fill, bit smask, bit tmask);
        logic [31:0] r;
        wait_idle();
        r = $urandom;
        write_reg(REG_FILL_VALUE, fill);
        write_reg(REG_SOURCE_MASK, {r[31:1], smask});
        write_reg(REG_TARGET_MASK, {r[30:0], tmask});
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Input driver.
    always @(negedge aclk) begin
        if (!word_pending) begin
            if (aresetn && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_word = pending_words.pop_front();
                s_tuser <= cur_word.action;
                s_tlast <= cur_word.last;
                s_tdata <= {4'b0, cur_word.pt_valid, cur_word.weight, cur_word.smp_valid,
                            cur_word.sample, cur_word.src, cur_word.tgt};
                s_tvalid <= 1'b1;
                word_pending = 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            apply_remap_word(cur_word);
            word_pending = 1'b0;
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_points.size() == 0) begin
                $error("unexpected result word: out_value %h, out_last %b", m_tdata, m_tlast);
                mismatches++;
            end else begin
                due = expected_points.pop_front();
                if (m_tdata !== due.value) begin
                    $error("out_value: expected %h, got %h", due.value, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== due.last) begin
                    $error("out_last: expected %b, got %b", due.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        logic [31:0] r;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words: field extremes, rounding of negative products, 32-bit
        // saturation on both sides, the unused action, and the last point.
        set_config(32'h8000_0000, 1'b0, 1'b0);
        queue_word(make_word(ACT_LOAD, 12'd0, 12'd0, 32'h8000_0000, 1'b1, 18'h0, 1'b0, 1'b0));
        queue_word(make_word(ACT_LOAD, 12'hFFF, 12'hFFF, 32'h7FFF_FFFF, 1'b0, 18'h3FFFF,
                             1'b1, 1'b1));
        queue_word(make_word(ACT_LOAD, 12'd0, 12'd5, 32'h0001_8000, 1'b1, 18'h0, 1'b0, 1'b0));
        queue_word(make_word(ACT_WEIGHT, 12'd0, 12'd0, 32'h0, 1'b0, 18'h20000, 1'b0, 1'b0));
        queue_word(make_word(ACT_WEIGHT, 12'd0, 12'hFFF, 32'h0, 1'b0, 18'h1FFFF, 1'b0, 1'b0));
        queue_word(make_word(ACT_WEIGHT, 12'hFFF, 12'd5, 32'h0, 1'b0, 18'h3FFFF, 1'b0, 1'b0));
        queue_word(make_word(ACT_WEIGHT, 12'd1, 12'd5, 32'h0, 1'b0, 18'h00001, 1'b0, 1'b0));
        queue_word(make_word(ACT_WEIGHT, 12'd2, 12'd0, 32'h0, 1'b0, 18'h1FFFF, 1'b0, 1'b0));
        queue_word(make_word(ACT_UNUSED, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 18'h3FFFF,
                             1'b1, 1'b1));
        queue_word(make_word(ACT_EMIT, 12'd0, 12'd0, 32'h0, 1'b0, 18'h0, 1'b1, 1'b0));
        queue_word(make_word(ACT_EMIT, 12'd0, 12'd0, 32'h0, 1'b0, 18'h0, 1'b0, 1'b0));
        queue_word(make_word(ACT_EMIT, 12'd0, 12'd0, 32'h0, 1'b0, 18'h0, 1'b1, 1'b0));
        queue_word(make_word(ACT_EMIT, 12'd0, 12'd0, 32'h0, 1'b0, 18'h0, 1'b0, 1'b1));
        queue_word(make_word(ACT_EMIT, 12'd0, 12'd0, 32'h0, 1'b0, 18'h0, 1'b1, 1'b1));
        wait_idle();

        // A long stretch with no idling on either side.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(100);
        wait_idle();
        send_idle_pct = DEFAULT_IDLE_PCT;
        recv_stall_pct = DEFAULT_IDLE_PCT;

        // Both masks on: an invalid column loads the fill value, a masked point
        // returns it and leaves the packed pointer alone.
        set_config(32'h7FFF_FFFF, 1'b1, 1'b1);
        queue_word(make_word(ACT_WEIGHT, 12'd0, 12'hFFF, 32'h0, 1'b0, 18'h15555, 1'b0, 1'b0));
        queue_word(make_word(ACT_WEIGHT, 12'd0, 12'd0, 32'h0, 1'b0, 18'h00001, 1'b0, 1'b0));
        queue_word(make_word(ACT_EMIT, 12'd0, 12'd0, 32'h0, 1'b0, 18'h0, 1'b0, 1'b0));
        queue_word(make_word(ACT_EMIT, 12'd0, 12'd0, 32'h0, 1'b0, 18'h0, 1'b1, 1'b1));
        random_phase(100);
        wait_idle();
        random_phase(100);

        r = $urandom;
        set_config(r, 1'b1, 1'b0);
        random_phase(150);

        set_config(32'h0, 1'b0, 1'b1);
        random_phase(150);

        r = $urandom;
        set_config(r, 1'b1, 1'b1);
        random_phase(150);

        wait_idle();
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
